// File: src/prt_pkg.sv
// ---------------------------------------------------------------------------
// prt_pkg: shared types and constants
// Command and event codes, the queued command beat and the slot count.
// ---------------------------------------------------------------------------
package prt_pkg;

    localparam int SLOTS            = 8;
    localparam int SLOT_W           = 3;
    localparam int RESPONSE_BUF_LEN = 128;
    localparam logic [7:0] ID_LOW   = 8'd1;
    localparam logic [7:0] ID_HIGH  = 8'd255;

    typedef enum logic [2:0] {
        CMD_SEND    = 3'd0,
        CMD_RX      = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_ABORT   = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_BAD     = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        EV_TRACKED   = 4'd0,
        EV_DONE_NOANS = 4'd1,
        EV_UNTRACKED = 4'd2,
        EV_KEEP      = 4'd3,
        EV_DONE_OK   = 4'd4,
        EV_OVERFLOW  = 4'd5,
        EV_TIMEOUT   = 4'd6,
        EV_ABORTED   = 4'd7,
        EV_UNMATCHED = 4'd8,
        EV_ACK       = 4'd9,
        EV_NO_SLOT   = 4'd10,
        EV_NO_ID     = 4'd11,
        EV_REJECTED  = 4'd12
    } ev_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        tracked;
        logic        needs_id;
        logic [7:0]  want_type;
        logic        multi;
        logic [30:0] timeout_ticks;
        logic [7:0]  rx_type;
        logic        frame_has_id;
        logic [7:0]  rx_frame_id;
        logic        too_long;
        logic [2:0]  target_slot;
        logic [7:0]  abort_code;
    } beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_EMIT,
        ST_FINAL,
        ST_WAIT
    } state_t;

endpackage

// File: src/pending_request_tracker.sv
// ---------------------------------------------------------------------------
// pending_request_tracker: outstanding request table
// Tracks up to eight requests, allocates frame ids and reports events.
// ---------------------------------------------------------------------------
// Commands enter on in_valid/in_ready; events leave on out_valid/out_ready.
// A two-beat queue decouples intake from the slot engine, so new commands
// are taken while an event waits for the receiver.
// Send, release and rejected commands give one event each. Id allocation
// tests one candidate id per cycle against all slots.
// Received frames scan one slot per cycle, up to all eight slots.
// Tick and abort scan all eight slots, one a cycle while no event waits
// for the receiver, giving one event per ended slot and a final ack beat.
// A stalled receiver holds the event register; the engine waits for it.
// Reset clears all slots, sets the next id to one and time to zero.
// ---------------------------------------------------------------------------
module pending_request_tracker
    import prt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic        tracked,
    input  logic        needs_id,
    input  logic [7:0]  want_type,
    input  logic        multi,
    input  logic [30:0] timeout_ticks,
    input  logic [7:0]  rx_type,
    input  logic        frame_has_id,
    input  logic [7:0]  rx_frame_id,
    input  logic [15:0] rx_len,
    input  logic [2:0]  target_slot,
    input  logic [7:0]  abort_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic [2:0]  slot,
    output logic [7:0]  out_id,
    output logic [7:0]  code,
    output logic        last
);

    logic  q_valid;
    logic  q_pop;
    beat_t q_beat;

    prt_front u_front (
        .clk, .rst_n, .valid(in_valid), .ready(in_ready),
        .command, .tracked, .needs_id, .want_type, .multi, .timeout_ticks,
        .rx_type, .frame_has_id, .rx_frame_id, .rx_len,
        .target_slot, .abort_code, .q_valid, .q_pop, .q_beat
    );

    prt_back u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_beat,
        .out_valid, .out_ready, .event_res, .slot, .out_id, .code, .last
    );

endmodule

// File: src/prt_front.sv
// ---------------------------------------------------------------------------
// prt_front: command intake
// Decodes a command beat and pushes it into a two-entry queue.
// ---------------------------------------------------------------------------
module prt_front
    import prt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [2:0]  command,
    input  logic        tracked,
    input  logic        needs_id,
    input  logic [7:0]  want_type,
    input  logic        multi,
    input  logic [30:0] timeout_ticks,
    input  logic [7:0]  rx_type,
    input  logic        frame_has_id,
    input  logic [7:0]  rx_frame_id,
    input  logic [15:0] rx_len,
    input  logic [2:0]  target_slot,
    input  logic [7:0]  abort_code,
    output logic        q_valid,
    input  logic        q_pop,
    output beat_t       q_beat
);

    beat_t      mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    beat_t      b;
    logic       push;

    always_comb
    begin
        b = '0;
        unique case (command)
            CMD_SEND:    b.cmd = CMD_SEND;
            CMD_RX:      b.cmd = CMD_RX;
            CMD_TICK:    b.cmd = CMD_TICK;
            CMD_ABORT:   b.cmd = CMD_ABORT;
            CMD_RELEASE: b.cmd = CMD_RELEASE;
            default:     b.cmd = CMD_BAD;
        endcase
        b.tracked       = tracked;
        b.needs_id      = needs_id;
        b.want_type     = want_type;
        b.multi         = multi;
        b.timeout_ticks = timeout_ticks;
        b.rx_type       = rx_type;
        b.frame_has_id  = frame_has_id;
        b.rx_frame_id   = rx_frame_id;
        b.too_long      = rx_len > 16'(RESPONSE_BUF_LEN);
        b.target_slot   = target_slot;
        b.abort_code    = abort_code;
    end

    assign ready   = cnt_reg != 2'd2;
    assign push    = valid && ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_beat  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// File: src/prt_back.sv
// ---------------------------------------------------------------------------
// prt_back: slot table engine
// Executes queued commands on the slot table, one slot per cycle while no event waits for the receiver.
// ---------------------------------------------------------------------------
module prt_back
    import prt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  beat_t       q_beat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic [2:0]  slot,
    output logic [7:0]  out_id,
    output logic [7:0]  code,
    output logic        last
);

    state_t      state_reg, state_next;
    beat_t       cur_reg, cur_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [7:0]  sid_reg [SLOTS];
    logic [7:0]  sexp_reg [SLOTS];
    logic        smul_reg [SLOTS];
    logic        sans_reg [SLOTS];
    logic [31:0] sdl_reg [SLOTS];
    logic [7:0]  nid_reg, nid_next;
    logic [31:0] now_reg, now_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [7:0]  tries_reg, tries_next;
    logic [7:0]  cand_reg, cand_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic        ov_reg, ov_next;
    logic [3:0]  ev_reg, ev_next;
    logic [2:0]  os_reg, os_next;
    logic [7:0]  oid_reg, oid_next;
    logic [7:0]  ocd_reg, ocd_next;
    logic        ol_reg, ol_next;
    logic        wr_en;
    logic        ans_set;
    logic        id_hit;
    logic        free_any;
    logic [SLOT_W-1:0] free_idx;
    logic        last_idx;
    logic        match;
    logic [31:0] diff;

    assign out_valid = ov_reg;
    assign event_res = ev_reg;
    assign slot      = os_reg;
    assign out_id    = oid_reg;
    assign code      = ocd_reg;
    assign last      = ol_reg;
    assign last_idx  = idx_reg == SLOT_W'(SLOTS - 1);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        id_hit   = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (busy_reg[i] && sid_reg[i] == cand_reg)
            begin
                id_hit = 1'b1;
            end
        end
    end

    assign match = busy_reg[idx_reg] && sexp_reg[idx_reg] == cur_reg.rx_type
        && (!cur_reg.frame_has_id || sid_reg[idx_reg] == cur_reg.rx_frame_id);
    assign diff  = now_reg - sdl_reg[idx_reg];

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        busy_next  = busy_reg;
        nid_next   = nid_reg;
        now_next   = now_reg;
        idx_next   = idx_reg;
        tries_next = tries_reg;
        cand_next  = cand_reg;
        free_next  = free_reg;
        ov_next    = ov_reg && !out_ready;
        ev_next    = ev_reg;
        os_next    = os_reg;
        oid_next   = oid_reg;
        ocd_next   = ocd_reg;
        ol_next    = ol_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        ans_set    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !ov_next)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_beat;
                    idx_next  = '0;
                    free_next = free_idx;
                    ov_next   = 1'b1;
                    os_next   = '0;
                    oid_next  = '0;
                    ocd_next  = '0;
                    ol_next   = 1'b1;
                    unique case (q_beat.cmd) inside
                        CMD_SEND:
                        begin
                            if (!q_beat.tracked)
                            begin
                                ev_next = EV_UNTRACKED;
                            end
                            else if (!free_any)
                            begin
                                ev_next = EV_NO_SLOT;
                            end
                            else if (q_beat.needs_id)
                            begin
                                ov_next    = 1'b0;
                                cand_next  = nid_reg;
                                tries_next = '0;
                                state_next = ST_ALLOC;
                            end
                            else
                            begin
                                ov_next    = 1'b0;
                                cand_next  = '0;
                                state_next = ST_FINAL;
                            end
                        end
                        CMD_RX, CMD_ABORT:
                        begin
                            ov_next    = 1'b0;
                            state_next = ST_SCAN;
                        end
                        CMD_TICK:
                        begin
                            ov_next    = 1'b0;
                            now_next   = now_reg + 32'd1;
                            state_next = ST_SCAN;
                        end
                        CMD_RELEASE:
                        begin
                            ev_next = EV_ACK;
                            os_next = q_beat.target_slot;
                            busy_next[SLOT_W'(q_beat.target_slot)] = 1'b0;
                        end
                        default:
                        begin
                            ev_next = EV_REJECTED;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                nid_next = (cand_reg == ID_HIGH || cand_reg == 8'd0) ? ID_LOW
                           : cand_reg + 8'd1;
                if (!id_hit)
                begin
                    state_next = ST_FINAL;
                end
                else if (tries_reg == ID_HIGH - 8'd1)
                begin
                    ov_next    = 1'b1;
                    ev_next    = EV_NO_ID;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tries_next = tries_reg + 8'd1;
                    cand_next  = nid_next;
                end
            end
            ST_FINAL:
            begin
                ov_next = 1'b1;
                if (cur_reg.want_type == 8'd0)
                begin
                    ev_next  = EV_DONE_NOANS;
                    oid_next = cand_reg;
                end
                else
                begin
                    ev_next  = EV_TRACKED;
                    os_next  = 3'(free_reg);
                    oid_next = cand_reg;
                    wr_en    = 1'b1;
                    busy_next[free_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!ov_next)
                begin
                    os_next  = 3'(idx_reg);
                    oid_next = sid_reg[idx_reg];
                    ocd_next = '0;
                    ol_next  = 1'b0;
                    if (cur_reg.cmd == CMD_RX)
                    begin
                        if (match)
                        begin
                            ov_next    = 1'b1;
                            ol_next    = 1'b1;
                            state_next = ST_IDLE;
                            if (cur_reg.too_long)
                            begin
                                ev_next = EV_OVERFLOW;
                                busy_next[idx_reg] = 1'b0;
                            end
                            else
                            begin
                                ans_set = 1'b1;
                                if (smul_reg[idx_reg])
                                begin
                                    ev_next = EV_KEEP;
                                end
                                else
                                begin
                                    ev_next = EV_DONE_OK;
                                    busy_next[idx_reg] = 1'b0;
                                end
                            end
                        end
                        else if (last_idx)
                        begin
                            ov_next    = 1'b1;
                            ol_next    = 1'b1;
                            ev_next    = EV_UNMATCHED;
                            os_next    = '0;
                            oid_next   = '0;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (busy_reg[idx_reg] &&
                             (cur_reg.cmd == CMD_ABORT || !diff[31]))
                    begin
                        ov_next = 1'b1;
                        busy_next[idx_reg] = 1'b0;
                        if (cur_reg.cmd == CMD_ABORT)
                        begin
                            ev_next  = EV_ABORTED;
                            ocd_next = cur_reg.abort_code;
                        end
                        else
                        begin
                            ev_next = (smul_reg[idx_reg] && sans_reg[idx_reg])
                                      ? EV_DONE_OK : EV_TIMEOUT;
                        end
                    end
                    if (state_next == ST_SCAN)
                    begin
                        if (last_idx)
                        begin
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (!ov_next)
                begin
                    ov_next    = 1'b1;
                    ev_next    = EV_ACK;
                    os_next    = '0;
                    oid_next   = '0;
                    ocd_next   = '0;
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        tries_reg <= tries_next;
        cand_reg  <= cand_next;
        free_reg  <= free_next;
        ev_reg    <= ev_next;
        os_reg    <= os_next;
        oid_reg   <= oid_next;
        ocd_reg   <= ocd_next;
        ol_reg    <= ol_next;
        if (wr_en)
        begin
            sid_reg[free_reg]  <= cand_reg;
            sexp_reg[free_reg] <= cur_reg.want_type;
            smul_reg[free_reg] <= cur_reg.multi;
            sans_reg[free_reg] <= 1'b0;
            sdl_reg[free_reg]  <= now_reg + {1'b0, cur_reg.timeout_ticks};
        end
        if (ans_set)
        begin
            sans_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= '0;
            nid_reg   <= ID_LOW;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            nid_reg   <= nid_next;
            now_reg   <= now_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// File: verif/tb_pending_request_tracker.sv
// ---------------------------------------------------------------------------
// tb_pending_request_tracker: self-checking bench for the request tracker
// Sends directed and random command beats, predicts every event from a
// local copy of the slot table, and compares each event field by field.
// ---------------------------------------------------------------------------
module tb_pending_request_tracker;
    import prt_pkg::*;

    typedef struct {
        logic [2:0]  command;
        logic        tracked;
        logic        needs_id;
        logic [7:0]  want_type;
        logic        multi;
        logic [30:0] timeout_ticks;
        logic [7:0]  rx_type;
        logic        frame_has_id;
        logic [7:0]  rx_frame_id;
        logic [15:0] rx_len;
        logic [2:0]  target_slot;
        logic [7:0]  abort_code;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic [2:0] slot;
        logic [7:0] out_id;
        logic [7:0] code;
        logic       last;
    } event_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  command = '0;
    logic        tracked = '0;
    logic        needs_id = '0;
    logic [7:0]  want_type = '0;
    logic        multi = '0;
    logic [30:0] timeout_ticks = '0;
    logic [7:0]  rx_type = '0;
    logic        frame_has_id = '0;
    logic [7:0]  rx_frame_id = '0;
    logic [15:0] rx_len = '0;
    logic [2:0]  target_slot = '0;
    logic [7:0]  abort_code = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  event_res;
    logic [2:0]  slot;
    logic [7:0]  out_id;
    logic [7:0]  code;
    logic        last;

    pending_request_tracker dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic        busy_m [SLOTS];
    logic [7:0]  id_m [SLOTS];
    logic [7:0]  exp_m [SLOTS];
    logic        multi_m [SLOTS];
    logic        ans_m [SLOTS];
    logic [31:0] dl_m [SLOTS];
    logic [7:0]  next_id_m;
    logic [31:0] now_m;

    event_beat_t pending_events [$];
    int errors = 0;
    int items_sent = 0;
    int events_seen = 0;
    int idle_cycles = 0;
    int hold_off = 0;

    function automatic event_beat_t mk(logic [3:0] e, logic [2:0] s, logic [7:0] id,
                                        logic [7:0] c, logic l);
        event_beat_t r;
        r.event_res = e;
        r.slot = s;
        r.out_id = id;
        r.code = c;
        r.last = l;
        return r;
    endfunction

    function automatic bit id_in_flight(logic [7:0] id);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (busy_m[i] && id_m[i] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_events(cmd_beat_t b);
        int fs;
        logic [7:0] id;
        logic [7:0] cand;
        bit got;
        bit hit;
        logic [31:0] diff;
        fs = SLOTS;
        id = 8'd0;
        got = 1'b0;
        hit = 1'b0;
        case (b.command)
            CMD_SEND:
            begin
                if (!b.tracked)
                begin
                    pending_events.push_back(mk(EV_UNTRACKED, 0, 0, 0, 1));
                    return;
                end
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!busy_m[i]) fs = i;
                if (fs == SLOTS)
                begin
                    pending_events.push_back(mk(EV_NO_SLOT, 0, 0, 0, 1));
                    return;
                end
                if (b.needs_id)
                begin
                    for (int n = 0; n < 255 && !got; n++)
                    begin
                        cand = next_id_m;
                        next_id_m = (next_id_m == ID_HIGH || next_id_m == 0) ? ID_LOW
                                    : next_id_m + 8'd1;
                        if (!id_in_flight(cand))
                        begin
                            id = cand;
                            got = 1'b1;
                        end
                    end
                    if (!got)
                    begin
                        pending_events.push_back(mk(EV_NO_ID, 0, 0, 0, 1));
                        return;
                    end
                end
                if (b.want_type == 0)
                begin
                    pending_events.push_back(mk(EV_DONE_NOANS, 0, id, 0, 1));
                    return;
                end
                busy_m[fs] = 1'b1;
                id_m[fs] = id;
                exp_m[fs] = b.want_type;
                multi_m[fs] = b.multi;
                ans_m[fs] = 1'b0;
                dl_m[fs] = now_m + {1'b0, b.timeout_ticks};
                pending_events.push_back(mk(EV_TRACKED, 3'(fs), id, 0, 1));
            end
            CMD_RX:
            begin
                for (int i = 0; i < SLOTS && !hit; i++)
                begin
                    if (busy_m[i] && exp_m[i] == b.rx_type
                        && (!b.frame_has_id || id_m[i] == b.rx_frame_id))
                    begin
                        hit = 1'b1;
                        if (b.rx_len > RESPONSE_BUF_LEN)
                        begin
                            busy_m[i] = 1'b0;
                            pending_events.push_back(mk(EV_OVERFLOW, 3'(i), id_m[i], 0, 1));
                        end
                        else
                        begin
                            ans_m[i] = 1'b1;
                            if (!multi_m[i])
                            begin
                                busy_m[i] = 1'b0;
                                pending_events.push_back(mk(EV_DONE_OK, 3'(i), id_m[i], 0, 1));
                            end
                            else
                                pending_events.push_back(mk(EV_KEEP, 3'(i), id_m[i], 0, 1));
                        end
                    end
                end
                if (!hit)
                    pending_events.push_back(mk(EV_UNMATCHED, 0, 0, 0, 1));
            end
            CMD_TICK:
            begin
                now_m = now_m + 32'd1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    diff = now_m - dl_m[i];
                    if (busy_m[i] && !diff[31])
                    begin
                        busy_m[i] = 1'b0;
                        pending_events.push_back(mk((multi_m[i] && ans_m[i]) ? EV_DONE_OK
                                                    : EV_TIMEOUT, 3'(i), id_m[i], 0, 0));
                    end
                end
                pending_events.push_back(mk(EV_ACK, 0, 0, 0, 1));
            end
            CMD_ABORT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (busy_m[i])
                    begin
                        busy_m[i] = 1'b0;
                        pending_events.push_back(mk(EV_ABORTED, 3'(i), id_m[i],
                                                    b.abort_code, 0));
                    end
                end
                pending_events.push_back(mk(EV_ACK, 0, 0, 0, 1));
            end
            CMD_RELEASE:
            begin
                busy_m[b.target_slot] = 1'b0;
                pending_events.push_back(mk(EV_ACK, b.target_slot, 0, 0, 1));
            end
            default:
                pending_events.push_back(mk(EV_REJECTED, 0, 0, 0, 1));
        endcase
    endtask

    // Sender bursts: a gap of random length is taken before each burst.
    int burst_left = 0;

    task automatic send_beat(cmd_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= b.command;
        tracked <= b.tracked;
        needs_id <= b.needs_id;
        want_type <= b.want_type;
        multi <= b.multi;
        timeout_ticks <= b.timeout_ticks;
        rx_type <= b.rx_type;
        frame_has_id <= b.frame_has_id;
        rx_frame_id <= b.rx_frame_id;
        rx_len <= b.rx_len;
        target_slot <= b.target_slot;
        abort_code <= b.abort_code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_events(b);
        items_sent++;
    endtask

    task automatic flush_sender();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        flush_sender();
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_beat_t blank(logic [2:0] c);
        cmd_beat_t b;
        b.command = c;
        b.tracked = 1'b1;
        b.needs_id = 1'b1;
        b.want_type = 8'd1;
        b.multi = 1'b0;
        b.timeout_ticks = 31'd3;
        b.rx_type = 8'd1;
        b.frame_has_id = 1'b0;
        b.rx_frame_id = 8'd0;
        b.rx_len = 16'd0;
        b.target_slot = 3'd0;
        b.abort_code = 8'd0;
        return b;
    endfunction

    function automatic cmd_beat_t rand_beat(bit structured);
        cmd_beat_t b;
        int k;
        int s;
        b.command = 3'($urandom_range(0, 7));
        b.tracked = 1'($urandom);
        b.needs_id = 1'($urandom);
        b.want_type = 8'($urandom);
        b.multi = 1'($urandom);
        b.timeout_ticks = 31'($urandom);
        b.rx_type = 8'($urandom);
        b.frame_has_id = 1'($urandom);
        b.rx_frame_id = 8'($urandom);
        b.rx_len = 16'($urandom);
        b.target_slot = 3'($urandom);
        b.abort_code = 8'($urandom);
        if (structured)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
            begin
                b.command = CMD_SEND;
                b.tracked = ($urandom_range(0, 9) != 0);
                b.want_type = ($urandom_range(0, 9) == 0) ? 8'd0
                              : 8'($urandom_range(1, 4));
                b.timeout_ticks = ($urandom_range(0, 19) == 0) ? 31'($urandom)
                                  : 31'($urandom_range(0, 6));
            end
            else if (k < 75)
            begin
                b.command = CMD_RX;
                b.rx_type = 8'($urandom_range(0, 4));
                s = $urandom_range(0, SLOTS - 1);
                if (busy_m[s] && $urandom_range(0, 2) != 0)
                begin
                    b.rx_type = exp_m[s];
                    b.rx_frame_id = id_m[s];
                end
                b.rx_len = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                           : 16'($urandom_range(0, RESPONSE_BUF_LEN + 1));
            end
            else if (k < 92)
                b.command = CMD_TICK;
            else if (k < 96)
                b.command = CMD_RELEASE;
            else if (k < 98)
                b.command = CMD_ABORT;
        end
        return b;
    endfunction

    task automatic test_directed();
        cmd_beat_t b;
        b = blank(CMD_SEND);
        b.tracked = 1'b0;
        send_beat(b);
        b = blank(CMD_SEND);
        b.want_type = 8'd0;
        send_beat(b);
        for (int i = 0; i < SLOTS; i++)
        begin
            b = blank(CMD_SEND);
            b.want_type = (i == 0) ? 8'd255 : 8'(i);
            b.multi = i[0];
            b.needs_id = (i != 3);
            b.timeout_ticks = (i == 7) ? 31'h7fffffff : 31'(i);
            send_beat(b);
        end
        b = blank(CMD_SEND);
        send_beat(b);
        b = blank(CMD_RX);
        b.rx_type = 8'd255;
        b.frame_has_id = 1'b1;
        b.rx_frame_id = 8'd3;
        b.rx_len = 16'hffff;
        send_beat(b);
        b = blank(CMD_RX);
        b.rx_type = 8'd1;
        b.rx_len = 16'd128;
        send_beat(b);
        b = blank(CMD_RX);
        b.rx_type = 8'd2;
        b.frame_has_id = 1'b1;
        b.rx_frame_id = 8'd255;
        send_beat(b);
        b = blank(CMD_RX);
        b.rx_type = 8'd0;
        send_beat(b);
        for (int i = 0; i < 4; i++)
            send_beat(blank(CMD_TICK));
        b = blank(CMD_RELEASE);
        b.target_slot = 3'd7;
        send_beat(b);
        b = blank(CMD_RELEASE);
        b.target_slot = 3'd6;
        send_beat(b);
        send_beat(blank(CMD_BAD));
        b = blank(CMD_BAD);
        b.command = 3'd7;
        send_beat(b);
        b = blank(CMD_ABORT);
        b.abort_code = 8'hff;
        send_beat(b);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_beat($urandom_range(0, 9) != 0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        cmd_beat_t b;
        hold_off = 200;
        for (int i = 0; i < 12; i++)
        begin
            b = blank(CMD_SEND);
            b.want_type = 8'($urandom_range(1, 255));
            send_beat(b);
        end
        b = blank(CMD_ABORT);
        b.abort_code = 8'h5a;
        send_beat(b);
        wait_drained();
    endtask

    task automatic test_id_wrap();
        cmd_beat_t b;
        for (int i = 0; i < 270; i++)
        begin
            b = blank(CMD_SEND);
            b.want_type = 8'd0;
            if (i % 40 == 0)
                b.want_type = 8'd9;
            send_beat(b);
        end
        b = blank(CMD_ABORT);
        b.abort_code = 8'($urandom);
        send_beat(b);
        wait_drained();
    endtask

    // The receiver stalls at random, with a repeating window of constant ready; hold_off forces a long stall.
    int pat = 0;
    always @(posedge clk)
    begin
        pat <= pat + 1;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (pat[7:6] == 2'd3)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        event_beat_t got;
        event_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {event_res, slot, out_id, code, last};
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.event_res !== want.event_res)
                    $display("%0t: event_res expected %0d actual %0d", $time,
                             want.event_res, got.event_res);
                if (got.slot !== want.slot)
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                if (got.out_id !== want.out_id)
                    $display("%0t: out_id expected %0d actual %0d", $time,
                             want.out_id, got.out_id);
                if (got.code !== want.code)
                    $display("%0t: code expected %0d actual %0d", $time, want.code, got.code);
                if (got.last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            busy_m[i] = 1'b0;
            id_m[i] = '0;
            exp_m[i] = '0;
            multi_m[i] = 1'b0;
            ans_m[i] = 1'b0;
            dl_m[i] = '0;
        end
        next_id_m = ID_LOW;
        now_m = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(50);
        test_id_wrap();
        test_random(50);
        $display("Sent %0d command beats and checked %0d event beats,", items_sent,
                 events_seen);
        $display("covering id wrap, full table, deadlines, matching and long stalls.");
        if (errors == 0 && pending_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
